// ===== design/ttrt_pkg.sv =====
// ============================================================================
// Tick task release table package
// Shared sizes, codes and item types for the slot chain and its controller.
// ============================================================================
package ttrt_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int CntW      = $clog2(NUM_SLOTS + 1);
  localparam int TaskW     = 8;
  localparam int MsW       = 32;
  localparam int TickW     = 29;

  // x / 10 == (x * 0xCCCCCCCD) >> 35 for every 32-bit x.
  localparam logic [MsW-1:0] Div10Recip = 32'hCCCCCCCD;
  localparam int             Div10Shift = 35;

  typedef enum logic [1:0] {
    KIND_ADD  = 2'd0,
    KIND_TICK = 2'd1,
    KIND_DEL  = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REPLY_ADD  = 2'd0,
    REPLY_DEL  = 2'd1,
    REPLY_REL  = 2'd2,
    REPLY_IDLE = 2'd3
  } reply_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DUP       = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]       kind;
    logic [TaskW-1:0] task_id;
    logic [MsW-1:0]   delay_ms;
    logic [MsW-1:0]   period_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       reply_kind;
    logic [1:0]       status;
    logic [TaskW-1:0] released_id;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic [TaskW-1:0] task_id;
    logic [TickW-1:0] countdown;
    logic [TickW-1:0] reload;
  } slot_t;

  typedef struct packed {
    logic shift;
    logic take;
    logic clr;
    logic load;
  } cell_ctl_t;

endpackage

// ===== design/ttrt_cell.sv =====
// ============================================================================
// Slot cell
// Holds one table slot and takes its next contents from its right neighbor,
// from the recirculated head slot, or from a newly added task.
// ============================================================================
module ttrt_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ttrt_pkg::cell_ctl_t ctl_i,
  input  ttrt_pkg::slot_t   right_i,
  input  logic              right_used_i,
  input  ttrt_pkg::slot_t   tail_i,
  input  ttrt_pkg::slot_t   new_i,
  output logic              used_o,
  output ttrt_pkg::slot_t   slot_o
);
  import ttrt_pkg::*;

  logic  used_q;
  slot_t slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else if (ctl_i.shift) begin
      used_q <= right_used_i;
    end else if (ctl_i.take || ctl_i.load) begin
      used_q <= 1'b1;
    end else if (ctl_i.clr) begin
      used_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      slot_q <= right_i;
    end else if (ctl_i.take) begin
      slot_q <= tail_i;
    end else if (ctl_i.load) begin
      slot_q <= new_i;
    end
  end

  assign used_o = used_q;
  assign slot_o = slot_q;

endmodule

// ===== design/ttrt_div10.sv =====
// ============================================================================
// Divide by ten
// Registered quotient of a 32-bit value by ten through a reciprocal multiply.
// ============================================================================
module ttrt_div10 (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [ttrt_pkg::MsW-1:0]     x_i,
  output logic [ttrt_pkg::TickW-1:0]   q_o
);
  import ttrt_pkg::*;

  logic [2*MsW-1:0] prod;
  logic [TickW-1:0] q_q;

  assign prod = {{MsW{1'b0}}, x_i} * {{MsW{1'b0}}, Div10Recip};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= prod[Div10Shift +: TickW];
    end
  end

  assign q_o = q_q;

endmodule

// ===== design/tick_task_release_table.sv =====
// ============================================================================
// Tick task release table
// Ordered task slot table with add, delete and tick release over a slot chain.
// ============================================================================
// The slots sit in a chain of cells in insertion order. Every add, delete and
// tick walks the chain once: on each step the head slot is examined and
// either rotated to the tail of the used slots or dropped. The next item is
// taken only once a command has finished. An add first divides its delay and
// then its period by ten on a shared multiplier. The last result of a command
// is loaded into the output register in its final busy cycle. A command of
// kind 3 is taken and causes nothing. Released ids leave in slot order. The
// walk waits at a release while an earlier release is pending and the output
// register still holds an item that has not been taken, and the final result
// waits for the output register in the same way, so such stalls lengthen the
// command.
module tick_task_release_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ttrt_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ttrt_pkg::out_item_t out_item_o
);
  import ttrt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIVD,
    S_DIVP,
    S_SCAN,
    S_DONE
  } state_e;

  state_e           state_q;
  kind_e            kind_q;
  logic [TaskW-1:0] id_q;
  logic [MsW-1:0]   delay_q;
  logic [MsW-1:0]   period_q;
  logic [TickW-1:0] qdly_q;
  logic [CntW-1:0]  cnt_q;
  logic [CntW-1:0]  steps_q;
  logic             found_q;
  logic             pend_valid_q;
  logic [TaskW-1:0] pend_id_q;
  logic             out_valid_q;
  out_item_t        out_q;

  slot_t            cell_slot [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] cell_used;
  cell_ctl_t        cell_ctl [NUM_SLOTS];

  logic             div_en;
  logic [MsW-1:0]   div_x;
  logic [TickW-1:0] div_q;

  slot_t            head;
  slot_t            tail_slot;
  slot_t            new_slot;
  logic             hit;
  logic             remove;
  logic             release_hit;
  logic             out_free;
  logic             step;
  logic             load_en;
  logic             emit;
  out_item_t        emit_item;

  ttrt_div10 u_div10 (
    .clk_i (clk_i),
    .en_i  (div_en),
    .x_i   (div_x),
    .q_o   (div_q)
  );

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    slot_t right_slot;
    logic  right_used;
    if (g < NUM_SLOTS - 1) begin : g_mid
      assign right_slot = cell_slot[g+1];
      assign right_used = cell_used[g+1];
    end else begin : g_end
      assign right_slot = '0;
      assign right_used = 1'b0;
    end
    ttrt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (cell_ctl[g]),
      .right_i      (right_slot),
      .right_used_i (right_used),
      .tail_i       (tail_slot),
      .new_i        (new_slot),
      .used_o       (cell_used[g]),
      .slot_o       (cell_slot[g])
    );
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;

  assign div_en = (state_q == S_DIVD) || (state_q == S_DIVP);
  assign div_x  = (state_q == S_DIVD) ? delay_q : period_q;

  assign new_slot.task_id   = id_q;
  assign new_slot.countdown = qdly_q;
  assign new_slot.reload    = div_q;

  always_comb begin
    head        = cell_slot[0];
    tail_slot   = head;
    hit         = (head.task_id == id_q);
    remove      = 1'b0;
    release_hit = 1'b0;
    case (kind_q)
      KIND_TICK: begin
        if (head.countdown != '0) begin
          tail_slot.countdown = head.countdown - 1'b1;
        end else begin
          release_hit         = 1'b1;
          tail_slot.countdown = head.reload;
          remove              = (head.reload == '0);
        end
      end
      KIND_DEL: remove = hit;
      default: ;
    endcase

    step = (state_q == S_SCAN) && (steps_q != '0) &&
           !(release_hit && pend_valid_q && !out_free);
    load_en = (state_q == S_DONE) && out_free && (kind_q == KIND_ADD) &&
              !found_q && (cnt_q != CntW'(NUM_SLOTS));

    emit      = 1'b0;
    emit_item = '0;
    if (step && release_hit && pend_valid_q) begin
      emit                  = 1'b1;
      emit_item.reply_kind  = REPLY_REL;
      emit_item.released_id = pend_id_q;
    end else if (state_q == S_DONE && out_free) begin
      emit           = 1'b1;
      emit_item.last = 1'b1;
      case (kind_q)
        KIND_ADD: begin
          emit_item.reply_kind = REPLY_ADD;
          if (found_q) begin
            emit_item.status = ST_DUP;
          end else if (cnt_q == CntW'(NUM_SLOTS)) begin
            emit_item.status = ST_FULL;
          end else begin
            emit_item.status = ST_OK;
          end
        end
        KIND_DEL: begin
          emit_item.reply_kind = REPLY_DEL;
          emit_item.status     = found_q ? ST_OK : ST_NOT_FOUND;
        end
        default: begin
          if (pend_valid_q) begin
            emit_item.reply_kind  = REPLY_REL;
            emit_item.released_id = pend_id_q;
          end else begin
            emit_item.reply_kind = REPLY_IDLE;
          end
        end
      endcase
    end

    for (int i = 0; i < NUM_SLOTS; i++) begin
      cell_ctl[i] = '0;
      if (step) begin
        if (CntW'(i) + 1'b1 < cnt_q) begin
          cell_ctl[i].shift = 1'b1;
        end else if (CntW'(i) + 1'b1 == cnt_q) begin
          cell_ctl[i].clr  = remove;
          cell_ctl[i].take = !remove;
        end
      end
      if (load_en && CntW'(i) == cnt_q) begin
        cell_ctl[i].load = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      kind_q       <= KIND_NONE;
      id_q         <= '0;
      delay_q      <= '0;
      period_q     <= '0;
      qdly_q       <= '0;
      cnt_q        <= '0;
      steps_q      <= '0;
      found_q      <= 1'b0;
      pend_valid_q <= 1'b0;
      pend_id_q    <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
        out_q       <= emit_item;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            kind_q       <= kind_e'(in_item_i.kind);
            id_q         <= in_item_i.task_id;
            delay_q      <= in_item_i.delay_ms;
            period_q     <= in_item_i.period_ms;
            steps_q      <= cnt_q;
            found_q      <= 1'b0;
            pend_valid_q <= 1'b0;
            if (in_item_i.kind == KIND_ADD) begin
              state_q <= S_DIVD;
            end else if (in_item_i.kind != KIND_NONE) begin
              state_q <= S_SCAN;
            end
          end
        end
        S_DIVD: state_q <= S_DIVP;
        S_DIVP: begin
          qdly_q  <= div_q;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (steps_q == '0) begin
            state_q <= S_DONE;
          end else if (step) begin
            steps_q <= steps_q - 1'b1;
            if (remove) begin
              cnt_q <= cnt_q - 1'b1;
            end
            if (hit && kind_q != KIND_TICK) begin
              found_q <= 1'b1;
            end
            if (release_hit) begin
              pend_valid_q <= 1'b1;
              pend_id_q    <= head.task_id;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            if (load_en) begin
              cnt_q <= cnt_q + 1'b1;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_used_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_used) == int'(cnt_q))
    else $error("used slot flags disagree with the slot count");

  a_walk_within_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (steps_q <= cnt_q))
    else $error("slot walk runs past the used slots");

  a_release_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && emit_item.reply_kind == REPLY_REL) |-> (kind_q == KIND_TICK))
    else $error("release item produced outside a tick");
`endif

endmodule
